### hdl/multi_pattern_matcher_core_defines.svh
// Assertion helpers for the matcher core.
`ifndef MULTI_PATTERN_MATCHER_CORE_DEFINES_SVH
`define MULTI_PATTERN_MATCHER_CORE_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define MPM_ASSERT_NOW(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("matcher check failed");

// cons must hold in the cycle after ante
`define MPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matcher sequence check failed");

`endif

### hdl/mpm_pkg.sv
package mpm_pkg;

    localparam int MAX_STATES    = 1024;
    localparam int ALPHABET_SIZE = 95;
    localparam int MAX_KEYWORDS  = 32;

    localparam int STATE_W    = $clog2(MAX_STATES);
    localparam int COUNT_W    = $clog2(MAX_STATES + 1);
    localparam int CHAR_W     = $clog2(ALPHABET_SIZE);
    localparam int GOTO_DEPTH = MAX_STATES * ALPHABET_SIZE;
    localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
    localparam int EDGE_W     = STATE_W + 1;
    localparam int KW_W       = $clog2(MAX_KEYWORDS + 1);
    localparam int MASK_W     = MAX_KEYWORDS;
    localparam int CODE_W     = 8;
    localparam int LOW_CHAR   = 32;
    localparam int HIGH_CHAR  = 126;

    // goto entry: top bit set means no edge
    localparam logic [EDGE_W-1:0] EDGE_NONE = {1'b1, {STATE_W{1'b0}}};

    typedef enum logic [2:0] {
        MODE_CLEAR    = 3'd0,
        MODE_KEY_CHAR = 3'd1,
        MODE_KEY_END  = 3'd2,
        MODE_BUILD    = 3'd3,
        MODE_RESTART  = 3'd4,
        MODE_SCAN     = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_FULL     = 3'd1,
        ERR_KEYWORDS = 3'd2,
        ERR_CHAR     = 3'd3,
        ERR_PHASE    = 3'd4
    } err_t;

    // per-node record
    typedef struct packed {
        logic [STATE_W-1:0] parent;
        logic [CHAR_W-1:0]  chr;
        logic [STATE_W-1:0] depth;
        logic [STATE_W-1:0] fail;
        logic [MASK_W-1:0]  mask;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    function automatic logic [GOTO_AW-1:0] goto_addr(input logic [STATE_W-1:0] node,
                                                      input logic [CHAR_W-1:0] chr);
        return GOTO_AW'(node) * GOTO_AW'(ALPHABET_SIZE) + GOTO_AW'(chr);
    endfunction

endpackage

### hdl/mpm_ram.sv
module mpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/multi_pattern_matcher_core.sv
// Aho-Corasick keyword matcher over printable characters 32..126. Pulse start
// with a word (mode, char_code) while busy is low; exactly one result word
// comes back on done for one cycle and cannot be stalled, so capture it then.
// Each mode steps through the registered reads of the goto and node memories:
// error replies, restart and the unused modes answer in the cycle after start;
// a keyword character on an existing edge needs only its goto read, one that
// allocates a node also sweeps its 95-entry goto row to "no edge"; end
// keyword reads and rewrites the node record; a scan character takes a goto
// read plus a node and a goto read per failure hop. Build first sweeps the
// 95 root edges, then makes one pass over all nodes per trie level, walking
// failure hops for each node deeper than one on its own level. After reset
// and after a clear word the block sweeps the root row with busy high.
`include "multi_pattern_matcher_core_defines.svh"

module multi_pattern_matcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [7:0]  char_code,
    output logic        done,
    output logic [9:0]  current_state,
    output logic        match_found,
    output logic [31:0] match_mask,
    output logic [10:0] node_count,
    output logic [2:0]  error_code
);

    localparam int SW = mpm_pkg::STATE_W;
    localparam int CW = mpm_pkg::CHAR_W;
    localparam int MW = mpm_pkg::MASK_W;
    localparam logic [CW-1:0] LAST_CHR = CW'(mpm_pkg::ALPHABET_SIZE - 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_CLR  = 11'b000_0000_0010,  // root row sweep
        S_INS  = 11'b000_0000_0100,  // goto lookup for keyword char
        S_ROW  = 11'b000_0000_1000,  // new node row sweep
        S_END  = 11'b000_0001_0000,  // tag keyword bit
        S_ROOT = 11'b000_0010_0000,  // fill missing root edges
        S_LVL  = 11'b000_0100_0000,  // level pass over nodes
        S_PAR  = 11'b000_1000_0000,  // parent record read
        S_GOW  = 11'b001_0000_0000,  // goto data back in failure walk
        S_FL   = 11'b010_0000_0000,  // failure hop
        S_MSK  = 11'b100_0000_0000   // target mask read
    } fsm_t;

    fsm_t state_reg, state_next;
    logic init_reg, init_next;

    logic [10:0]   states_used_reg, states_used_next;
    logic [SW-1:0] insert_node_reg, insert_node_next;
    logic [SW-1:0] insert_depth_reg, insert_depth_next;
    logic [SW-1:0] max_depth_reg, max_depth_next;
    logic [mpm_pkg::KW_W-1:0] kw_count_reg, kw_count_next;
    logic [SW-1:0] scan_node_reg, scan_node_next;
    logic          built_reg, built_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [CW-1:0] chr_reg, chr_next;
    logic [CW-1:0] fchr_reg, fchr_next;
    logic [SW-1:0] walk_reg, walk_next;
    logic [SW-1:0] target_reg, target_next;
    logic [SW-1:0] lvl_reg, lvl_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic          bld_reg, bld_next;
    mpm_pkg::node_t cur_reg, cur_next;

    logic        done_reg;
    logic [9:0]  current_state_reg;
    logic        match_found_reg;
    logic [31:0] match_mask_reg;
    logic [10:0] node_count_reg;
    logic [2:0]  error_code_reg;

    // memory ports
    logic [SW-1:0]  g_rnode, g_wnode;
    logic [CW-1:0]  g_rchr, g_wchr;
    logic           g_we;
    logic [mpm_pkg::EDGE_W-1:0] g_wdata, g_rdata;
    logic           n_we;
    logic [SW-1:0]  n_waddr, n_raddr;
    mpm_pkg::node_t n_wdata, n_rdata;

    // finish strobe
    logic           fin;
    logic [SW-1:0]  fin_st;
    logic           fin_found;
    logic [MW-1:0]  fin_mask;
    mpm_pkg::err_t  fin_err;

    logic do_adv, do_levels;
    logic chr_ok;
    logic [CW-1:0] chr_in;
    logic [SW-1:0] last_idx;
    mpm_pkg::node_t wr_node;

    assign chr_ok   = (char_code >= 8'(mpm_pkg::LOW_CHAR)) &&
                      (char_code <= 8'(mpm_pkg::HIGH_CHAR));
    assign chr_in   = CW'(char_code - 8'(mpm_pkg::LOW_CHAR));
    assign last_idx = SW'(states_used_reg - 11'd1);

    mpm_ram #(
        .WIDTH (mpm_pkg::EDGE_W),
        .DEPTH (mpm_pkg::GOTO_DEPTH)
    ) u_goto (
        .clk   (clk),
        .we    (g_we),
        .waddr (mpm_pkg::goto_addr(g_wnode, g_wchr)),
        .wdata (g_wdata),
        .raddr (mpm_pkg::goto_addr(g_rnode, g_rchr)),
        .rdata (g_rdata)
    );

    mpm_ram #(
        .WIDTH (mpm_pkg::NODE_W),
        .DEPTH (mpm_pkg::MAX_STATES)
    ) u_node (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        init_next         = init_reg;
        states_used_next  = states_used_reg;
        insert_node_next  = insert_node_reg;
        insert_depth_next = insert_depth_reg;
        max_depth_next    = max_depth_reg;
        kw_count_next     = kw_count_reg;
        scan_node_next    = scan_node_reg;
        built_next        = built_reg;
        cnt_next          = cnt_reg;
        chr_next          = chr_reg;
        fchr_next         = fchr_reg;
        walk_next         = walk_reg;
        target_next       = target_reg;
        lvl_next          = lvl_reg;
        idx_next          = idx_reg;
        bld_next          = bld_reg;
        cur_next          = cur_reg;

        g_rnode = '0;
        g_rchr  = '0;
        g_we    = 1'b0;
        g_wnode = '0;
        g_wchr  = '0;
        g_wdata = mpm_pkg::EDGE_NONE;
        n_we    = 1'b0;
        n_waddr = '0;
        n_wdata = '0;
        n_raddr = '0;
        wr_node = n_rdata;

        fin       = 1'b0;
        fin_st    = '0;
        fin_found = 1'b0;
        fin_mask  = '0;
        fin_err   = mpm_pkg::ERR_OK;
        do_adv    = 1'b0;
        do_levels = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (mpm_pkg::mode_t'(mode))
                        mpm_pkg::MODE_CLEAR:
                        begin
                            states_used_next  = 11'd1;
                            insert_node_next  = '0;
                            insert_depth_next = '0;
                            max_depth_next    = '0;
                            kw_count_next     = '0;
                            scan_node_next    = '0;
                            built_next        = 1'b0;
                            cnt_next          = '0;
                            state_next        = S_CLR;
                        end
                        mpm_pkg::MODE_KEY_CHAR:
                        begin
                            fin_st = insert_node_reg;
                            if (built_reg)
                            begin
                                fin     = 1'b1;
                                fin_err = mpm_pkg::ERR_PHASE;
                            end
                            else if (!chr_ok)
                            begin
                                fin     = 1'b1;
                                fin_err = mpm_pkg::ERR_CHAR;
                            end
                            else if (kw_count_reg >= mpm_pkg::KW_W'(mpm_pkg::MAX_KEYWORDS))
                            begin
                                fin     = 1'b1;
                                fin_err = mpm_pkg::ERR_KEYWORDS;
                            end
                            else
                            begin
                                chr_next   = chr_in;
                                g_rnode    = insert_node_reg;
                                g_rchr     = chr_in;
                                state_next = S_INS;
                            end
                        end
                        mpm_pkg::MODE_KEY_END:
                        begin
                            fin_st = insert_node_reg;
                            if (built_reg)
                            begin
                                fin     = 1'b1;
                                fin_err = mpm_pkg::ERR_PHASE;
                            end
                            else if (kw_count_reg >= mpm_pkg::KW_W'(mpm_pkg::MAX_KEYWORDS))
                            begin
                                fin     = 1'b1;
                                fin_err = mpm_pkg::ERR_KEYWORDS;
                            end
                            else
                            begin
                                n_raddr    = insert_node_reg;
                                state_next = S_END;
                            end
                        end
                        mpm_pkg::MODE_BUILD:
                        begin
                            if (built_reg)
                            begin
                                fin     = 1'b1;
                                fin_err = mpm_pkg::ERR_PHASE;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_ROOT;
                            end
                        end
                        mpm_pkg::MODE_RESTART:
                        begin
                            fin = 1'b1;
                            if (!built_reg)
                            begin
                                fin_err = mpm_pkg::ERR_PHASE;
                            end
                            else
                            begin
                                scan_node_next = '0;
                            end
                        end
                        mpm_pkg::MODE_SCAN:
                        begin
                            fin_st = scan_node_reg;
                            if (!built_reg)
                            begin
                                fin     = 1'b1;
                                fin_err = mpm_pkg::ERR_PHASE;
                            end
                            else if (!chr_ok)
                            begin
                                fin     = 1'b1;
                                fin_err = mpm_pkg::ERR_CHAR;
                            end
                            else
                            begin
                                fchr_next  = chr_in;
                                walk_next  = scan_node_reg;
                                bld_next   = 1'b0;
                                g_rnode    = scan_node_reg;
                                g_rchr     = chr_in;
                                state_next = S_GOW;
                            end
                        end
                        default:
                        begin
                            fin     = 1'b1;
                            fin_err = mpm_pkg::ERR_PHASE;
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                g_we    = 1'b1;
                g_wchr  = cnt_reg;
                n_we    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CHR)
                begin
                    fin        = !init_reg;
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            S_INS:
            begin
                if (g_rdata[SW])
                begin
                    if (states_used_reg >= 11'(mpm_pkg::MAX_STATES))
                    begin
                        fin        = 1'b1;
                        fin_st     = insert_node_reg;
                        fin_err    = mpm_pkg::ERR_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        g_we    = 1'b1;
                        g_wnode = insert_node_reg;
                        g_wchr  = chr_reg;
                        g_wdata = {1'b0, SW'(states_used_reg)};
                        n_we    = 1'b1;
                        n_waddr = SW'(states_used_reg);
                        n_wdata = '{parent: insert_node_reg, chr: chr_reg,
                                    depth: insert_depth_reg + 1'b1, fail: '0, mask: '0};
                        insert_node_next  = SW'(states_used_reg);
                        insert_depth_next = insert_depth_reg + 1'b1;
                        states_used_next  = states_used_reg + 11'd1;
                        if (insert_depth_reg + 1'b1 > max_depth_reg)
                        begin
                            max_depth_next = insert_depth_reg + 1'b1;
                        end
                        cnt_next   = '0;
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    insert_node_next  = g_rdata[SW-1:0];
                    insert_depth_next = insert_depth_reg + 1'b1;
                    if (insert_depth_reg + 1'b1 > max_depth_reg)
                    begin
                        max_depth_next = insert_depth_reg + 1'b1;
                    end
                    fin        = 1'b1;
                    fin_st     = g_rdata[SW-1:0];
                    state_next = S_IDLE;
                end
            end

            S_ROW:
            begin
                g_we     = 1'b1;
                g_wnode  = insert_node_reg;
                g_wchr   = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CHR)
                begin
                    fin        = 1'b1;
                    fin_st     = insert_node_reg;
                    state_next = S_IDLE;
                end
            end

            S_END:
            begin
                wr_node      = n_rdata;
                wr_node.mask = n_rdata.mask | (MW'(1) << kw_count_reg);
                n_we         = 1'b1;
                n_waddr      = insert_node_reg;
                n_wdata      = wr_node;
                kw_count_next     = kw_count_reg + 1'b1;
                insert_node_next  = '0;
                insert_depth_next = '0;
                fin        = 1'b1;
                fin_st     = insert_node_reg;
                state_next = S_IDLE;
            end

            S_ROOT:
            begin
                // read issued for cnt the cycle before, except the very first
                g_rchr = cnt_reg + 1'b1;
                if (bld_reg)
                begin
                    if (g_rdata[SW])
                    begin
                        g_we    = 1'b1;
                        g_wchr  = cnt_reg;
                        g_wdata = '0;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CHR)
                    begin
                        do_levels = 1'b1;
                    end
                end
                else
                begin
                    g_rchr   = '0;
                    bld_next = 1'b1;
                end
            end

            S_LVL:
            begin
                cur_next = n_rdata;
                if (n_rdata.depth == lvl_reg)
                begin
                    if (lvl_reg == SW'(1))
                    begin
                        wr_node      = n_rdata;
                        wr_node.fail = '0;
                        n_we    = 1'b1;
                        n_waddr = idx_reg;
                        n_wdata = wr_node;
                        do_adv  = 1'b1;
                    end
                    else
                    begin
                        n_raddr    = n_rdata.parent;
                        state_next = S_PAR;
                    end
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end

            S_PAR:
            begin
                walk_next  = n_rdata.fail;
                fchr_next  = cur_reg.chr;
                g_rnode    = n_rdata.fail;
                g_rchr     = cur_reg.chr;
                state_next = S_GOW;
            end

            S_GOW:
            begin
                if (g_rdata[SW])
                begin
                    n_raddr    = walk_reg;
                    state_next = S_FL;
                end
                else
                begin
                    target_next = g_rdata[SW-1:0];
                    n_raddr     = g_rdata[SW-1:0];
                    state_next  = S_MSK;
                end
            end

            S_FL:
            begin
                walk_next  = n_rdata.fail;
                g_rnode    = n_rdata.fail;
                g_rchr     = fchr_reg;
                state_next = S_GOW;
            end

            S_MSK:
            begin
                if (bld_reg)
                begin
                    wr_node      = cur_reg;
                    wr_node.fail = target_reg;
                    wr_node.mask = cur_reg.mask | n_rdata.mask;
                    n_we    = 1'b1;
                    n_waddr = idx_reg;
                    n_wdata = wr_node;
                    do_adv  = 1'b1;
                end
                else
                begin
                    scan_node_next = target_reg;
                    fin        = 1'b1;
                    fin_st     = target_reg;
                    fin_mask   = n_rdata.mask;
                    fin_found  = |n_rdata.mask;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // start of level passes, or done when the trie has no nodes
        if (do_levels)
        begin
            if (max_depth_reg == '0)
            begin
                do_adv = 1'b0;
                built_next     = 1'b1;
                scan_node_next = '0;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                lvl_next   = SW'(1);
                idx_next   = SW'(1);
                n_raddr    = SW'(1);
                state_next = S_LVL;
            end
        end

        // next node of the pass, next level, or build done
        if (do_adv)
        begin
            if (idx_reg == last_idx)
            begin
                if (lvl_reg == max_depth_reg)
                begin
                    built_next     = 1'b1;
                    scan_node_next = '0;
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    idx_next   = SW'(1);
                    n_raddr    = SW'(1);
                    state_next = S_LVL;
                end
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                n_raddr    = idx_reg + 1'b1;
                state_next = S_LVL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            init_reg         <= 1'b1;
            states_used_reg  <= 11'd1;
            insert_node_reg  <= '0;
            insert_depth_reg <= '0;
            max_depth_reg    <= '0;
            kw_count_reg     <= '0;
            scan_node_reg    <= '0;
            built_reg        <= 1'b0;
            cnt_reg          <= '0;
            bld_reg          <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            init_reg         <= init_next;
            states_used_reg  <= states_used_next;
            insert_node_reg  <= insert_node_next;
            insert_depth_reg <= insert_depth_next;
            max_depth_reg    <= max_depth_next;
            kw_count_reg     <= kw_count_next;
            scan_node_reg    <= scan_node_next;
            built_reg        <= built_next;
            cnt_reg          <= cnt_next;
            // build flag doubles as "first root read issued"
            bld_reg          <= (state_next == S_ROOT && state_reg != S_ROOT) ? 1'b0 : bld_next;
            done_reg         <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg    <= chr_next;
        fchr_reg   <= fchr_next;
        walk_reg   <= walk_next;
        target_reg <= target_next;
        lvl_reg    <= lvl_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        if (fin)
        begin
            current_state_reg <= fin_st;
            match_found_reg   <= fin_found;
            match_mask_reg    <= 32'(fin_mask);
            node_count_reg    <= states_used_next;
            error_code_reg    <= fin_err;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign current_state = current_state_reg;
    assign match_found   = match_found_reg;
    assign match_mask    = match_mask_reg;
    assign node_count    = node_count_reg;
    assign error_code    = error_code_reg;

    `MPM_ASSERT_NOW(a_count_range, (states_used_reg != 11'd0) && (states_used_reg <= 11'(mpm_pkg::MAX_STATES)))
    `MPM_ASSERT_NOW(a_insert_alloc, 11'(insert_node_reg) < states_used_reg)
    `MPM_ASSERT_NOW(a_found_mask, !(done_reg && match_found_reg) || (match_mask_reg != 32'd0))
    `MPM_ASSERT_NEXT(a_scan_phase, start && !busy && (mode == mpm_pkg::MODE_SCAN) && !built_reg, done_reg && (error_code_reg == mpm_pkg::ERR_PHASE))

endmodule
